FILE: src/cowm_pkg.sv
// ----------------------------------------------------------------------------
// cowm_pkg
// Shared widths, types and control structs of the clock offset median block.
// ----------------------------------------------------------------------------
package cowm_pkg;

  localparam int unsigned IN_W       = 40;
  localparam int unsigned OFF_W      = 39;
  localparam int unsigned HELD_W     = 8;
  localparam int unsigned WINDOW_DEF = 128;

  typedef logic signed [OFF_W-1:0] offset_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RING,
    ST_MERGE,
    ST_DONE
  } state_e;

  // Start of one sorted-copy update.
  typedef struct packed {
    logic    start;
    logic    removing;
    offset_t new_val;
    offset_t old_val;
  } merge_req_t;

  typedef struct packed {
    logic    done;
    offset_t median;
  } merge_sts_t;

endpackage

FILE: src/cowm_if.sv
// ----------------------------------------------------------------------------
// cowm_in_if / cowm_out_if
// Valid/ready channels for transit samples and median results.
// ----------------------------------------------------------------------------
interface cowm_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [cowm_pkg::IN_W-1:0]   client_to_server_us;
  logic signed [cowm_pkg::IN_W-1:0]   server_to_client_us;

  modport source (output valid, client_to_server_us, server_to_client_us, input ready);
  modport sink   (input valid, client_to_server_us, server_to_client_us, output ready);
endinterface

interface cowm_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [cowm_pkg::OFF_W-1:0]  median_offset_us;
  logic        [cowm_pkg::HELD_W-1:0] samples_held;

  modport source (output valid, median_offset_us, samples_held, input ready);
  modport sink   (input valid, median_offset_us, samples_held, output ready);
endinterface

FILE: src/cowm_ring_ram.sv
// ----------------------------------------------------------------------------
// cowm_ring_ram
// Arrival-order ring of offsets, one write and one registered read port.
// ----------------------------------------------------------------------------
module cowm_ring_ram #(
  parameter int unsigned WINDOW = cowm_pkg::WINDOW_DEF,
  localparam int unsigned IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
  input  logic              clk_i,
  input  logic              rd_en_i,
  input  logic [IDX_W-1:0]  rd_addr_i,
  output cowm_pkg::offset_t rd_data_o,
  input  logic              wr_en_i,
  input  logic [IDX_W-1:0]  wr_addr_i,
  input  cowm_pkg::offset_t wr_data_i
);
  import cowm_pkg::*;

  offset_t ring_mem [WINDOW];
  offset_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= ring_mem[rd_addr_i];
    end
    if (wr_en_i) begin
      ring_mem[wr_addr_i] <= wr_data_i;
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: src/cowm_sort_merge.sv
// ----------------------------------------------------------------------------
// cowm_sort_merge
// Sorted copy of the window in two banks; each update streams the old bank
// into the other, dropping the evicted value and inserting the new one.
// ----------------------------------------------------------------------------
module cowm_sort_merge #(
  parameter int unsigned WINDOW = cowm_pkg::WINDOW_DEF,
  localparam int unsigned IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1,
  localparam int unsigned CNT_W = $clog2(WINDOW + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cowm_pkg::merge_req_t req_i,
  input  logic [CNT_W-1:0]     fill_i,
  output cowm_pkg::merge_sts_t sts_o
);
  import cowm_pkg::*;

  offset_t sort_mem [2][WINDOW];

  logic             active_q, rvalid_q, pend_rm_q, bank_q, done_q;
  logic [CNT_W-1:0] ra_q, wa_q, n_q, k_q;
  logic [CNT_W-1:0] n_new;
  offset_t          carry_q, carry_d, old_q, rdata_q, median_q, wr_data;
  logic             rd_fire, flush, skip, take, lt, wr_en;

  assign n_new = req_i.removing ? fill_i : fill_i + CNT_W'(1);

  // Streaming insertion: emit the smaller of carry and the element read,
  // keep the larger in carry; the last carry closes the new bank.
  always_comb begin
    rd_fire = active_q && (ra_q < n_q);
    flush   = active_q && !rd_fire && !rvalid_q;
    skip    = rvalid_q && pend_rm_q && (rdata_q == old_q);
    take    = rvalid_q && !skip;
    lt      = rdata_q < carry_q;
    wr_en   = take || flush;
    if (flush) begin
      wr_data = carry_q;
    end else if (lt) begin
      wr_data = rdata_q;
    end else begin
      wr_data = carry_q;
    end
    carry_d = (take && !lt) ? rdata_q : carry_q;
  end

  always_ff @(posedge clk_i) begin
    if (rd_fire) begin
      rdata_q <= sort_mem[bank_q][ra_q[IDX_W-1:0]];
    end
    if (wr_en) begin
      sort_mem[!bank_q][wa_q[IDX_W-1:0]] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      carry_q <= req_i.new_val;
      old_q   <= req_i.old_val;
    end else if (take) begin
      carry_q <= carry_d;
    end
    if (wr_en && (wa_q == k_q)) begin
      median_q <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      rvalid_q  <= 1'b0;
      pend_rm_q <= 1'b0;
      bank_q    <= 1'b0;
      done_q    <= 1'b0;
      ra_q      <= '0;
      wa_q      <= '0;
      n_q       <= '0;
      k_q       <= '0;
    end else begin
      done_q <= flush && !req_i.start;
      if (req_i.start) begin
        active_q  <= 1'b1;
        rvalid_q  <= 1'b0;
        pend_rm_q <= req_i.removing;
        ra_q      <= '0;
        wa_q      <= '0;
        n_q       <= fill_i;
        k_q       <= n_new >> 1;
      end else if (active_q) begin
        rvalid_q <= rd_fire;
        if (rd_fire) begin
          ra_q <= ra_q + CNT_W'(1);
        end
        if (skip) begin
          pend_rm_q <= 1'b0;
        end
        if (take) begin
          wa_q <= wa_q + CNT_W'(1);
        end
        if (flush) begin
          active_q <= 1'b0;
          bank_q   <= !bank_q;
        end
      end
    end
  end

  assign sts_o.done   = done_q;
  assign sts_o.median = median_q;

endmodule

FILE: src/clock_offset_window_median_top.sv
// ----------------------------------------------------------------------------
// clock_offset_window_median_top
// Sliding-window upper median of clock offsets from two transit samples.
// ----------------------------------------------------------------------------
//  Channel  Dir  Beat contents
//  in_i     in   client_to_server_us, server_to_client_us (signed 40 bit)
//  out_o    out  median_offset_us (signed 39 bit), samples_held (8 bit)
//
// For each beat, the merge walk reads every entry of the sorted bank once
// through its single read port. One sample is worked on at a time;
// in_i.ready is high only between items. A result waiting on out_o does
// not block the next input beat, only the delivery of the following
// result. Reset clears counters and control; the memories need no
// clearing since values of unfilled entries are never used.
// ----------------------------------------------------------------------------
module clock_offset_window_median_top #(
  parameter int unsigned WINDOW = cowm_pkg::WINDOW_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  cowm_in_if.sink    in_i,
  cowm_out_if.source out_o
);
  import cowm_pkg::*;

  localparam int unsigned IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned CNT_W = $clog2(WINDOW + 1);

  state_e             state_q, state_d;
  logic [IDX_W-1:0]   slot_q;
  logic [CNT_W-1:0]   fill_q;
  offset_t            offset_q, offset_sat, ring_rdata, med_q;
  logic               out_valid_q;
  logic [HELD_W-1:0]  held_q;
  logic [31:0]        fill_ext;

  logic               in_ready, ring_rd, ring_wr, load_out, in_fire;
  logic signed [IN_W:0] diff, sum, half;
  merge_req_t         req;
  merge_sts_t         sts;

  // Halve toward zero: add one to negative differences before the shift, then saturate.
  always_comb begin
    diff = {in_i.client_to_server_us[IN_W-1], in_i.client_to_server_us}
         - {in_i.server_to_client_us[IN_W-1], in_i.server_to_client_us};
    sum  = diff + {{IN_W{1'b0}}, diff[IN_W]};
    half = {sum[IN_W], sum[IN_W:1]};
    if (!half[IN_W] && (half[IN_W-1:OFF_W-1] != '0)) begin
      offset_sat = {1'b0, {(OFF_W-1){1'b1}}};
    end else if (half[IN_W] && (half[IN_W-1:OFF_W-1] != '1)) begin
      offset_sat = {1'b1, {(OFF_W-1){1'b0}}};
    end else begin
      offset_sat = half[OFF_W-1:0];
    end
  end

  assign in_fire = in_i.valid && in_ready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_i.valid) state_d = ST_RING;
      ST_RING:  state_d = ST_MERGE;
      ST_MERGE: if (sts.done) state_d = ST_DONE;
      ST_DONE:  if (!out_valid_q || out_o.ready) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    ring_rd  = 1'b0;
    ring_wr  = 1'b0;
    load_out = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready = 1'b1;
        ring_rd  = in_i.valid;
      end
      ST_RING:  ring_wr  = 1'b1;
      ST_MERGE: ;
      ST_DONE:  load_out = !out_valid_q || out_o.ready;
      default: ;
    endcase
  end

  // The evicted value is read in the accept cycle and arrives in the ring
  // cycle, when the new offset overwrites that entry.
  always_comb begin
    req.start    = ring_wr;
    req.removing = (fill_q == CNT_W'(WINDOW));
    req.new_val  = offset_q;
    req.old_val  = ring_rdata;
  end

  cowm_ring_ram #(.WINDOW(WINDOW)) u_ring (
    .clk_i     (clk_i),
    .rd_en_i   (ring_rd),
    .rd_addr_i (slot_q),
    .rd_data_o (ring_rdata),
    .wr_en_i   (ring_wr),
    .wr_addr_i (slot_q),
    .wr_data_i (offset_q)
  );

  cowm_sort_merge #(.WINDOW(WINDOW)) u_merge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .fill_i (fill_q),
    .sts_o  (sts)
  );

  assign fill_ext = 32'(fill_q);

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      offset_q <= offset_sat;
    end
    if (load_out) begin
      med_q  <= sts.median;
      held_q <= fill_ext[HELD_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      slot_q      <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ring_wr) begin
        slot_q <= (slot_q == IDX_W'(WINDOW - 1)) ? '0 : slot_q + IDX_W'(1);
        if (fill_q != CNT_W'(WINDOW)) begin
          fill_q <= fill_q + CNT_W'(1);
        end
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_i.ready             = in_ready;
  assign out_o.valid            = out_valid_q;
  assign out_o.median_offset_us = med_q;
  assign out_o.samples_held     = held_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(WINDOW)) else $error("fill count above window");

  a_accept_to_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == ST_RING)) else $error("accepted beat did not start ring access");

  a_done_in_merge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.done |-> (state_q == ST_MERGE)) else $error("merge finished outside merge state");

  a_load_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> (!out_valid_q || out_o.ready)) else $error("result overwrote pending beat");

endmodule

FILE: test/clock_offset_window_median_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// clock_offset_window_median_top_test
// Checks the sliding-window clock offset median against a local predictor.
// Transit sample pairs go in through a queue-fed driver. A monitor compares
// every median beat with the oldest predicted one. The run steps through
// phases of sender gaps and receiver stalls, long receiver hold-offs and
// full drains before the sender continues.
// ----------------------------------------------------------------------------
module clock_offset_window_median_top_test;
  import cowm_pkg::*;

  typedef logic signed [IN_W-1:0] transit_t;
  typedef logic [HELD_W-1:0]      held_t;

  typedef struct {
    transit_t    c2s;
    transit_t    s2c;
    int unsigned gap_pct;
    int unsigned stall_pct;
    bit          drain_first;
    bit          hold_rx;
  } transit_pair_t;

  typedef struct packed {
    offset_t median;
    held_t   held;
  } median_beat_t;

  localparam transit_t    TRANSIT_MAX    = {1'b0, {(IN_W-1){1'b1}}};
  localparam transit_t    TRANSIT_MIN    = {1'b1, {(IN_W-1){1'b0}}};
  localparam longint      OFFSET_MAX     = (64'sd1 <<< (OFF_W - 1)) - 1;
  localparam longint      OFFSET_MIN     = -OFFSET_MAX - 1;
  localparam longint      HALVING        = 2;
  localparam int unsigned RX_HOLD_CYCLES = 3 * WINDOW_DEF + 200;
  localparam int unsigned SETTLE_CYCLES  = WINDOW_DEF + 16;

  logic clk_i = 1'b0;
  logic rst_ni;

  cowm_in_if  transit_if ();
  cowm_out_if median_if ();

  clock_offset_window_median_top #(
    .WINDOW(WINDOW_DEF)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (transit_if),
    .out_o (median_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  transit_pair_t pending_pairs[$];
  median_beat_t  predicted_medians[$];

  // Predictor state, a copy of the block's ring.
  longint      offset_ring[WINDOW_DEF];
  int unsigned next_slot  = 0;
  int unsigned fill_count = 0;

  int unsigned mismatches   = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned rx_hold_left = 0;
  bit          rx_hold_req  = 1'b0;
  bit          pair_taken   = 1'b0;

  function automatic median_beat_t predict_median(transit_t c2s, transit_t s2c);
    longint       sorted[WINDOW_DEF];
    longint       offset;
    longint       v;
    int unsigned  i;
    int unsigned  j;
    median_beat_t r;
    // Integer division truncates toward zero, as the block must.
    offset = (longint'(c2s) - longint'(s2c)) / HALVING;
    if (offset > OFFSET_MAX) begin
      offset = OFFSET_MAX;
    end else if (offset < OFFSET_MIN) begin
      offset = OFFSET_MIN;
    end
    offset_ring[next_slot] = offset;
    next_slot = (next_slot + 1) % WINDOW_DEF;
    if (fill_count < WINDOW_DEF) fill_count++;
    for (i = 0; i < fill_count; i++) begin
      v = offset_ring[i];
      j = i;
      while (j > 0 && sorted[j-1] > v) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = v;
    end
    r.median = offset_t'(sorted[fill_count / 2]);
    r.held   = held_t'(fill_count);
    return r;
  endfunction

  task automatic queue_pair(transit_t c2s, transit_t s2c, int unsigned gap_pct,
                            int unsigned stall_pct, bit drain_first, bit hold_rx);
    transit_pair_t p;
    p.c2s         = c2s;
    p.s2c         = s2c;
    p.gap_pct     = gap_pct;
    p.stall_pct   = stall_pct;
    p.drain_first = drain_first;
    p.hold_rx     = hold_rx;
    pending_pairs.push_back(p);
  endtask

  function automatic transit_t any_transit();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[IN_W-1:0];
  endfunction

  function automatic transit_t near_transit(longint span);
    return transit_t'(longint'($urandom_range(0, 2 * span)) - span);
  endfunction

  task automatic queue_random_phase(int unsigned count, int unsigned gap_pct,
                                    int unsigned stall_pct, int unsigned hold_at);
    transit_t    c2s;
    transit_t    s2c;
    int unsigned pick;
    int unsigned k;
    for (k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        // Typical sync traffic: modest transits, offsets cluster.
        c2s = near_transit(20000);
        s2c = near_transit(20000);
      end else if (pick < 55) begin
        // Tiny values give repeated offsets and odd negative differences.
        c2s = near_transit(4);
        s2c = near_transit(4);
      end else if (pick < 75) begin
        c2s = any_transit();
        s2c = any_transit();
      end else if (pick < 88) begin
        // Close to both saturation limits.
        if ($urandom_range(0, 1) != 0) begin
          c2s = TRANSIT_MAX - transit_t'($urandom_range(0, 3));
          s2c = TRANSIT_MIN + transit_t'($urandom_range(0, 3));
        end else begin
          c2s = TRANSIT_MIN + transit_t'($urandom_range(0, 3));
          s2c = TRANSIT_MAX - transit_t'($urandom_range(0, 3));
        end
        if ($urandom_range(0, 2) == 0) s2c = near_transit(4);
      end else begin
        c2s = any_transit();
        s2c = near_transit(1000);
        if ($urandom_range(0, 1) != 0) begin
          s2c = c2s;
          c2s = near_transit(1000);
        end
      end
      queue_pair(c2s, s2c, gap_pct, stall_pct, k == 0 || $urandom_range(0, 99) == 0,
                 k == hold_at);
    end
  endtask

  // Driver: offers the next pending pair at the falling edge.
  always @(negedge clk_i) begin
    transit_pair_t p;
    if (rst_ni && (!transit_if.valid || pair_taken)) begin
      pair_taken = 1'b0;
      if (pending_pairs.size() != 0 &&
          !(pending_pairs[0].drain_first && predicted_medians.size() != 0) &&
          $urandom_range(0, 99) >= pending_pairs[0].gap_pct) begin
        p = pending_pairs.pop_front();
        transit_if.valid               <= 1'b1;
        transit_if.client_to_server_us <= p.c2s;
        transit_if.server_to_client_us <= p.s2c;
        rx_stall_pct                   <= p.stall_pct;
        if (p.hold_rx) rx_hold_req = 1'b1;
      end else begin
        transit_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni || rx_hold_left != 0) begin
      median_if.ready <= 1'b0;
    end else begin
      median_if.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // Long receiver hold-off, counted here so the sender keeps offering.
  always @(posedge clk_i) begin
    if (rx_hold_req) begin
      rx_hold_req  = 1'b0;
      rx_hold_left = RX_HOLD_CYCLES;
    end else if (rx_hold_left != 0) begin
      rx_hold_left--;
    end
  end

  // Monitor: the result beat is checked before this edge's input beat is
  // predicted, so a result can never be matched with its own input.
  always @(posedge clk_i) begin
    median_beat_t want;
    if (rst_ni && median_if.valid && median_if.ready) begin
      if (predicted_medians.size() == 0) begin
        $error("unexpected result beat: median_offset_us %0d, samples_held %0d",
               $signed(median_if.median_offset_us), median_if.samples_held);
        mismatches++;
      end else begin
        want = predicted_medians.pop_front();
        if (median_if.median_offset_us !== want.median) begin
          $error("median_offset_us: expected %0d, got %0d",
                 $signed(want.median), $signed(median_if.median_offset_us));
          mismatches++;
        end
        if (median_if.samples_held !== want.held) begin
          $error("samples_held: expected %0d, got %0d",
                 want.held, median_if.samples_held);
          mismatches++;
        end
      end
    end
    if (rst_ni && transit_if.valid && transit_if.ready) begin
      predicted_medians.push_back(predict_median(transit_if.client_to_server_us,
                                                 transit_if.server_to_client_us));
      pair_taken = 1'b1;
    end
  end

  initial begin
    rst_ni                         = 1'b0;
    transit_if.valid               = 1'b0;
    transit_if.client_to_server_us = '0;
    transit_if.server_to_client_us = '0;
    median_if.ready                = 1'b0;

    // Directed pairs: zero, both saturation limits, exact limits,
    // truncation of odd differences toward zero, alternating bit patterns.
    queue_pair('0, '0, 0, 0, 0, 0);
    queue_pair(TRANSIT_MAX, TRANSIT_MIN, 0, 0, 0, 0);
    queue_pair(TRANSIT_MIN, TRANSIT_MAX, 0, 0, 0, 0);
    queue_pair(TRANSIT_MAX, TRANSIT_MAX, 0, 0, 0, 0);
    queue_pair(TRANSIT_MIN, TRANSIT_MIN, 0, 0, 0, 0);
    queue_pair(TRANSIT_MAX, transit_t'(1), 0, 0, 0, 0);
    queue_pair(TRANSIT_MAX, transit_t'(-1), 0, 0, 0, 0);
    queue_pair(TRANSIT_MIN, '0, 0, 0, 0, 0);
    queue_pair(TRANSIT_MIN, transit_t'(1), 0, 0, 0, 0);
    queue_pair(TRANSIT_MIN, transit_t'(2), 0, 0, 0, 0);
    queue_pair(transit_t'(-3), '0, 0, 0, 0, 0);
    queue_pair(transit_t'(3), '0, 0, 0, 0, 0);
    queue_pair('0, transit_t'(3), 0, 0, 0, 0);
    queue_pair(transit_t'(-1), '0, 0, 0, 0, 0);
    queue_pair(transit_t'(1), '0, 0, 0, 0, 0);
    queue_pair(transit_t'(40'hAA_AAAA_AAAA), transit_t'(40'h55_5555_5555), 0, 0, 0, 0);
    queue_pair(transit_t'(40'h55_5555_5555), transit_t'(40'hAA_AAAA_AAAA), 0, 0, 0, 0);
    queue_pair(transit_t'(1000), transit_t'(1000), 0, 0, 0, 0);

    // The window fills during the first phase and wraps many times after.
    queue_random_phase(200, 0, 0, 120);
    queue_random_phase(250, 57, 0, 0);
    queue_random_phase(250, 0, 57, 0);
    queue_random_phase(250, 29, 29, 0);

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_pairs.size() != 0 || transit_if.valid) @(posedge clk_i);
    while (predicted_medians.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
